[rtl/http_header_end_and_length_detector_core_macros.svh]
// Assertion macros for the HTTP header end and length detector
`ifndef HTTP_HEADER_END_AND_LENGTH_DETECTOR_CORE_MACROS_SVH
`define HTTP_HEADER_END_AND_LENGTH_DETECTOR_CORE_MACROS_SVH

// checked on every rising edge outside reset
`define HHED_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked whenever a result word is on offer
`define HHED_ASSERT_OUT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) out_valid |-> (prop)) \
		else $error(msg);

`endif

[rtl/hhed_pkg.sv]
// Shared types and constants for the HTTP header end and length detector
`timescale 1ns / 1ps

package hhed_pkg;

	localparam int MAX_PACKET_BYTES = 65536;
	localparam int POS_W = $clog2(MAX_PACKET_BYTES + 1);
	localparam int HIST = 14;
	localparam int END_LEN = 4;

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [7:0] BLANK_LINE [END_LEN] = '{CH_CR, CH_LF, CH_CR, CH_LF};

	// "Content-Length"
	localparam logic [7:0] LEN_NAME [HIST] = '{
		8'h43, 8'h6F, 8'h6E, 8'h74, 8'h65, 8'h6E, 8'h74,
		8'h2D, 8'h4C, 8'h65, 8'h6E, 8'h67, 8'h74, 8'h68
	};

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_SKIP,
		PH_SPACE,
		PH_DIGITS,
		PH_DONE
	} phase_t;

	// next-state view of the pattern matcher
	typedef struct packed {
		logic             end_seen;
		logic [POS_W-1:0] end_pos;
		logic             name_seen;
	} mtch_t;

	// next-state view of the number parser
	typedef struct packed {
		logic [31:0] value;
		logic        negative;
		logic        clamped;
	} num_t;

endpackage

[rtl/http_header_end_and_length_detector_core.sv]
// Top level of the HTTP header end and Content-Length detector.
// Throughput one byte word per cycle while in_ready is high; each byte passes through the input register.
// Results are registered: the last byte passes the input register, where a full result
// register can hold it, and its result word is then offered from the result register.
// in_ready falls only while the staged last byte waits on a full result register.
// arst_n clears all match and parse state; state also clears after every result.
`timescale 1ns / 1ps

module http_header_end_and_length_detector_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [7:0]                 data_byte,
	input  logic                       last_byte,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       header_found,
	output logic [16:0]                header_bytes,
	output logic                       length_known,
	output logic [31:0]                body_length,
	output logic                       length_saturated
);
	import hhed_pkg::*;

	`include "http_header_end_and_length_detector_core_macros.svh"

	logic        vld_s1;
	logic [7:0]  data_s1;
	logic        last_s1;
	logic        consume;
	logic        done;
	logic        step;
	logic        name_hit;
	mtch_t       mtch;
	num_t        num;
	logic [31:0] len_val;

	logic        out_valid_q;
	logic        found_q;
	logic [16:0] size_q;
	logic        known_q;
	logic [31:0] length_q;
	logic        sat_q;

	assign consume  = vld_s1 && (!last_s1 || !out_valid_q || out_ready);
	assign done     = consume && last_s1;
	assign in_ready = !vld_s1 || consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	hhed_match u_match (
		.clk      (clk),
		.arst_n   (arst_n),
		.consume  (consume),
		.clear    (done),
		.data     (data_s1),
		.step     (step),
		.name_hit (name_hit),
		.mtch     (mtch)
	);

	hhed_number u_number (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.clear    (done),
		.name_hit (name_hit),
		.data     (data_s1),
		.num      (num)
	);

	always_comb begin
		priority if (!mtch.name_seen || num.clamped) begin
			len_val = '1;
		end else if (num.negative) begin
			len_val = (~num.value) + 32'd1;
		end else begin
			len_val = num.value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			found_q  <= mtch.end_seen;
			size_q   <= mtch.end_seen ? 17'(mtch.end_pos) : 17'd0;
			known_q  <= mtch.name_seen;
			length_q <= len_val;
			sat_q    <= mtch.name_seen && num.clamped;
		end
	end

	assign out_valid        = out_valid_q;
	assign header_found     = found_q;
	assign header_bytes     = size_q;
	assign length_known     = known_q;
	assign body_length      = length_q;
	assign length_saturated = sat_q;

	`HHED_ASSERT(a_result_from_last, $rose(out_valid_q) |-> $past(done), "result without last word")
	`HHED_ASSERT(a_stall_cause, !in_ready |-> (vld_s1 && last_s1 && out_valid_q), "bad input stall")
	`HHED_ASSERT_OUT(a_size_zero, header_found || header_bytes == 17'd0, "size without header end")
	`HHED_ASSERT_OUT(a_unknown_len, length_known || (body_length == '1 && !length_saturated), "bad unknown length")

endmodule

[rtl/hhed_match.sv]
// Byte window, position count and blank line / length name matching
`timescale 1ns / 1ps

module hhed_match (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     consume,
	input  logic                     clear,
	input  logic [7:0]               data,
	output logic                     step,
	output logic                     name_hit,
	output hhed_pkg::mtch_t          mtch
);
	import hhed_pkg::*;

	logic [7:0]       hist_q [HIST-1];
	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] pos_n;
	logic             end_seen_q;
	logic [POS_W-1:0] end_pos_q;
	logic             name_seen_q;
	logic             end_hit;
	logic             name_eq;
	logic [7:0]       win [HIST];

	always_comb begin
		for (int i = 0; i < HIST - 1; i++) begin
			win[i] = hist_q[i];
		end
		win[HIST-1] = data;
	end

	assign step  = consume && (pos_q < POS_W'(MAX_PACKET_BYTES));
	assign pos_n = pos_q + 1'b1;

	always_comb begin
		end_hit = step && !end_seen_q && (pos_n >= POS_W'(END_LEN));
		for (int i = 0; i < END_LEN; i++) begin
			if (win[HIST-END_LEN+i] != BLANK_LINE[i]) end_hit = 1'b0;
		end
		name_eq = 1'b1;
		for (int i = 0; i < HIST; i++) begin
			if (win[i] != LEN_NAME[i]) name_eq = 1'b0;
		end
	end

	assign name_hit = step && !name_seen_q && (pos_n >= POS_W'(HIST)) && name_eq;

	assign mtch.end_seen  = end_seen_q || end_hit;
	assign mtch.end_pos   = end_hit ? pos_n : end_pos_q;
	assign mtch.name_seen = name_seen_q || name_hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HIST - 1; i++) begin
				hist_q[i] <= '0;
			end
			pos_q       <= '0;
			end_seen_q  <= 1'b0;
			end_pos_q   <= '0;
			name_seen_q <= 1'b0;
		end else if (clear) begin
			for (int i = 0; i < HIST - 1; i++) begin
				hist_q[i] <= '0;
			end
			pos_q       <= '0;
			end_seen_q  <= 1'b0;
			end_pos_q   <= '0;
			name_seen_q <= 1'b0;
		end else if (step) begin
			for (int i = 0; i < HIST - 2; i++) begin
				hist_q[i] <= hist_q[i+1];
			end
			hist_q[HIST-2] <= data;
			pos_q          <= pos_n;
			end_seen_q     <= mtch.end_seen;
			end_pos_q      <= mtch.end_pos;
			name_seen_q    <= mtch.name_seen;
		end
	end

endmodule

[rtl/hhed_number.sv]
// Decimal value parser that follows the length name
`timescale 1ns / 1ps

module hhed_number (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic              clear,
	input  logic              name_hit,
	input  logic [7:0]        data,
	output hhed_pkg::num_t    num
);
	import hhed_pkg::*;

	phase_t      ph_q, ph_d;
	logic [31:0] val_q, val_d;
	logic        neg_q, neg_d;
	logic        clamp_q, clamp_d;
	logic        is_digit;
	logic        is_space;
	logic [35:0] sum;
	logic [31:0] take_val;
	logic        take_clamp;

	assign is_digit = (data >= CH_ZERO) && (data <= CH_NINE);
	assign is_space = (data == CH_SP) || ((data >= CH_TAB) && (data <= CH_CR));

	// value * 10 + digit as two shifts and two adds
	assign sum = {1'b0, val_q, 3'b000} + {3'b000, val_q, 1'b0} + {32'd0, data[3:0]};

	always_comb begin
		if (clamp_q) begin
			take_val   = val_q;
			take_clamp = 1'b1;
		end else if (sum[35:32] != 4'd0) begin
			take_val   = '1;
			take_clamp = 1'b1;
		end else begin
			take_val   = sum[31:0];
			take_clamp = 1'b0;
		end
	end

	always_comb begin
		ph_d    = ph_q;
		val_d   = val_q;
		neg_d   = neg_q;
		clamp_d = clamp_q;
		if (step) begin
			unique case (ph_q)
				PH_SKIP: begin
					ph_d = PH_SPACE;
				end
				PH_SPACE: begin
					priority if (is_space) begin
						ph_d = PH_SPACE;
					end else if (data == CH_PLUS || data == CH_MINUS) begin
						neg_d = (data == CH_MINUS);
						ph_d  = PH_DIGITS;
					end else if (is_digit) begin
						val_d   = take_val;
						clamp_d = take_clamp;
						ph_d    = PH_DIGITS;
					end else begin
						ph_d = PH_DONE;
					end
				end
				PH_DIGITS: begin
					if (is_digit) begin
						val_d   = take_val;
						clamp_d = take_clamp;
					end else begin
						ph_d = PH_DONE;
					end
				end
				PH_IDLE, PH_DONE: begin
					ph_d = ph_q;
				end
				default: begin
					ph_d = PH_IDLE;
				end
			endcase
		end
		if (name_hit) begin
			ph_d = PH_SKIP;
		end
	end

	assign num.value    = val_d;
	assign num.negative = neg_d;
	assign num.clamped  = clamp_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q    <= PH_IDLE;
			val_q   <= '0;
			neg_q   <= 1'b0;
			clamp_q <= 1'b0;
		end else if (clear) begin
			ph_q    <= PH_IDLE;
			val_q   <= '0;
			neg_q   <= 1'b0;
			clamp_q <= 1'b0;
		end else begin
			ph_q    <= ph_d;
			val_q   <= val_d;
			neg_q   <= neg_d;
			clamp_q <= clamp_d;
		end
	end

endmodule

[tb/http_header_end_and_length_detector_core_tb.sv]
// Self-checking testbench for the HTTP header end and Content-Length detector core
`timescale 1ns / 1ps

module http_header_end_and_length_detector_core_tb;
	import hhed_pkg::*;

	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;

	typedef struct packed {
		logic        hdr_found;
		logic [16:0] hdr_size;
		logic        len_known;
		logic [31:0] body_len;
		logic        len_sat;
	} framing_t;

	class header_len_scoreboard;
		logic [7:0]  window [HIST];
		int unsigned pos;
		bit          end_seen;
		int unsigned end_pos;
		bit          name_seen;
		phase_t      phase;
		logic [31:0] value;
		bit          negative;
		bit          clamped;
		framing_t    framing_q [$];
		int unsigned mismatches;

		function new();
			mismatches = 0;
			clear_buffer_state();
		endfunction

		function void clear_buffer_state();
			foreach (window[i]) window[i] = 8'h00;
			pos = 0;
			end_seen = 0;
			end_pos = 0;
			name_seen = 0;
			phase = PH_IDLE;
			value = '0;
			negative = 0;
			clamped = 0;
		endfunction

		function void take_digit(logic [7:0] c);
			longint unsigned acc;
			if (clamped)
				return;
			acc = value;
			acc = acc * 10 + (c - CH_ZERO);
			if (acc > 64'hFFFF_FFFF) begin
				value = '1;
				clamped = 1;
			end else begin
				value = acc[31:0];
			end
		endfunction

		function void parse_byte(logic [7:0] c);
			bit is_digit;
			is_digit = (c >= CH_ZERO && c <= CH_NINE);
			case (phase)
				PH_SKIP: phase = PH_SPACE;
				PH_SPACE: begin
					if (!(c == CH_SP || (c >= CH_TAB && c <= CH_CR))) begin
						if (c == CH_PLUS || c == CH_MINUS) begin
							negative = (c == CH_MINUS);
							phase = PH_DIGITS;
						end else if (is_digit) begin
							take_digit(c);
							phase = PH_DIGITS;
						end else begin
							phase = PH_DONE;
						end
					end
				end
				PH_DIGITS: begin
					if (is_digit)
						take_digit(c);
					else
						phase = PH_DONE;
				end
				default: ;
			endcase
		endfunction

		function void note_word(logic [7:0] c, logic fin);
			framing_t r;
			bit hit;
			if (pos < MAX_PACKET_BYTES) begin
				parse_byte(c);
				for (int i = 0; i < HIST - 1; i++)
					window[i] = window[i + 1];
				window[HIST - 1] = c;
				pos++;
				if (!end_seen && pos >= END_LEN) begin
					hit = 1;
					for (int k = 0; k < END_LEN; k++)
						if (window[HIST - END_LEN + k] != BLANK_LINE[k])
							hit = 0;
					if (hit) begin
						end_seen = 1;
						end_pos = pos;
					end
				end
				if (!name_seen && pos >= HIST) begin
					hit = 1;
					for (int k = 0; k < HIST; k++)
						if (window[k] != LEN_NAME[k])
							hit = 0;
					if (hit) begin
						name_seen = 1;
						phase = PH_SKIP;
					end
				end
			end
			if (!fin)
				return;
			r.hdr_found = end_seen;
			r.hdr_size = end_seen ? end_pos[16:0] : 17'd0;
			r.len_known = name_seen;
			r.len_sat = name_seen && clamped;
			if (!name_seen || clamped)
				r.body_len = '1;
			else if (negative)
				r.body_len = 32'd0 - value;
			else
				r.body_len = value;
			framing_q = {framing_q, r};
			clear_buffer_state();
		endfunction

		function void check_result(logic hf, logic [16:0] hs, logic lk, logic [31:0] bl,
			logic ls);
			framing_t e;
			if (framing_q.size() == 0) begin
				$display("%0t: unexpected result word hf=%0b size=%0d known=%0b len=%0d sat=%0b",
					$realtime, hf, hs, lk, bl, ls);
				mismatches++;
				return;
			end
			e = framing_q.pop_front();
			if (hf !== e.hdr_found) begin
				$display("%0t: header_found expected %0b got %0b", $realtime, e.hdr_found, hf);
				mismatches++;
			end
			if (hs !== e.hdr_size) begin
				$display("%0t: header_bytes expected %0d got %0d", $realtime, e.hdr_size, hs);
				mismatches++;
			end
			if (lk !== e.len_known) begin
				$display("%0t: length_known expected %0b got %0b", $realtime, e.len_known, lk);
				mismatches++;
			end
			if (bl !== e.body_len) begin
				$display("%0t: body_length expected %0d got %0d", $realtime, e.body_len, bl);
				mismatches++;
			end
			if (ls !== e.len_sat) begin
				$display("%0t: length_saturated expected %0b got %0b", $realtime, e.len_sat, ls);
				mismatches++;
			end
		endfunction

		function int pending();
			return framing_q.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  data_byte;
	logic        last_byte;
	logic        out_valid;
	logic        out_ready;
	logic        header_found;
	logic [16:0] header_bytes;
	logic        length_known;
	logic [31:0] body_length;
	logic        length_saturated;

	header_len_scoreboard sb;
	logic [7:0] pkt_bytes [$];
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	int unsigned rx_hold_left;
	int unsigned bytes_sent;

	http_header_end_and_length_detector_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.header_found(header_found),
		.header_bytes(header_bytes),
		.length_known(length_known),
		.body_length(body_length),
		.length_saturated(length_saturated)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	initial begin
		#2_000_000;
		$display("FAIL http_header_end_and_length_detector_core");
		$finish;
	end

	// result words are stable at the falling edge ahead of the accepting edge
	always @(negedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(header_found, header_bytes, length_known, body_length,
				length_saturated);
	end

	initial begin
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rx_hold_left > 0) begin
				out_ready <= 1'b0;
				rx_hold_left--;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	function automatic void append_byte(logic [7:0] b);
		pkt_bytes = {pkt_bytes, b};
	endfunction

	function automatic void put_text(string s);
		for (int i = 0; i < s.len(); i++)
			append_byte(s[i]);
	endfunction

	function automatic void put_crlf();
		append_byte(CH_CR);
		append_byte(CH_LF);
	endfunction

	function automatic void build_random_buffer();
		int    kind;
		int    n;
		int    cut;
		string name_txt;
		pkt_bytes.delete();
		kind = $urandom_range(9);
		if (kind == 0) begin
			n = $urandom_range(1, 20);
			repeat (n) append_byte(8'($urandom_range(255)));
		end else if (kind == 1) begin
			// near misses: pieces of the name and of the blank line
			name_txt = "Content-Length: ";
			n = $urandom_range(1, 30);
			repeat (n) begin
				case ($urandom_range(3))
					0: append_byte(CH_CR);
					1: append_byte(CH_LF);
					2: append_byte(8'(CH_ZERO + $urandom_range(9)));
					default: append_byte(name_txt[$urandom_range(15)]);
				endcase
			end
		end else begin
			if ($urandom_range(1))
				put_text("GET /index.html HTTP/1.1");
			else
				put_text("HTTP/1.1 200 OK");
			put_crlf();
			if ($urandom_range(1)) begin
				put_text("Host: x");
				put_crlf();
			end
			if ($urandom_range(9) != 0) begin
				case ($urandom_range(9))
					0: name_txt = "content-length";
					1: name_txt = "Content-Lenght";
					default: name_txt = "Content-Length";
				endcase
				put_text(name_txt);
				append_byte(($urandom_range(4) != 0) ? CH_COLON : 8'($urandom_range(255)));
				repeat ($urandom_range(3)) begin
					case ($urandom_range(5))
						0: append_byte(CH_TAB);
						1: append_byte(CH_LF);
						2: append_byte(CH_VT);
						3: append_byte(CH_FF);
						4: append_byte(CH_CR);
						default: append_byte(CH_SP);
					endcase
				end
				case ($urandom_range(3))
					0: append_byte(CH_MINUS);
					1: append_byte(CH_PLUS);
					default: ;
				endcase
				case ($urandom_range(9))
					0: put_text("4294967295");
					1: put_text("4294967296");
					2: repeat ($urandom_range(10, 14))
						append_byte(8'(CH_ZERO + $urandom_range(9)));
					default: repeat ($urandom_range(4))
						append_byte(8'(CH_ZERO + $urandom_range(9)));
				endcase
				put_crlf();
			end
			if ($urandom_range(1)) begin
				put_text("Accept: */*");
				put_crlf();
			end
			if ($urandom_range(9) != 0)
				put_crlf();
			repeat ($urandom_range(6)) append_byte(8'($urandom_range(255)));
			if ($urandom_range(6) == 0) begin
				cut = $urandom_range(1, pkt_bytes.size());
				while (pkt_bytes.size() > cut)
					void'(pkt_bytes.pop_back());
			end
		end
	endfunction

	task automatic send_word(input logic [7:0] b, input logic fin);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		last_byte <= fin;
		@(negedge clk);
		while (!in_ready)
			@(negedge clk);
		@(posedge clk);
		sb.note_word(b, fin);
		bytes_sent++;
	endtask

	task automatic send_buffer();
		for (int i = 0; i < pkt_bytes.size(); i++)
			send_word(pkt_bytes[i], i == pkt_bytes.size() - 1);
	endtask

	task automatic wait_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic run_random(input int n_buf, input int n_bytes);
		int done_buf;
		int start_bytes;
		done_buf = 0;
		start_bytes = bytes_sent;
		while (done_buf < n_buf || bytes_sent - start_bytes < n_bytes) begin
			build_random_buffer();
			send_buffer();
			done_buf++;
		end
	endtask

	task automatic send_text(input string s, input bit blank_after);
		put_text(s);
		put_crlf();
		if (blank_after)
			put_crlf();
		send_buffer();
		pkt_bytes.delete();
	endtask

	initial begin
		sb = new();
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		data_byte <= 8'h00;
		last_byte <= 1'b0;
		send_idle_pct = 20;
		recv_idle_pct = 76;
		rx_hold_left = 0;
		bytes_sent = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed buffers
		pkt_bytes.delete();
		put_text("GET / HTTP/1.1");
		put_crlf();
		put_text("Content-Length: 42");
		put_crlf();
		put_crlf();
		put_text("body");
		send_buffer();
		pkt_bytes.delete();
		append_byte(8'h00);
		send_buffer();
		pkt_bytes.delete();
		append_byte(8'hFF);
		send_buffer();
		pkt_bytes.delete();
		send_text("Content-Length: -5", 1);
		send_text("Content-Length: 4294967295", 1);
		send_text("Content-Length: 4294967296", 1);
		send_text("Content-Length: -99999999999", 1);
		send_text("Content-Length: abc", 1);
		send_text("Content-Length: +x", 1);
		send_text("Content-Length9 +17", 1);
		send_text("content-length: 3", 1);
		send_text("Content-Length: 1", 0);
		send_text("Content-Length: 2 Content-Length: 7", 1);
		// name on the last word, then value cut off by the end of the buffer
		put_text("xContent-Length");
		send_buffer();
		pkt_bytes.delete();
		put_text("Content-Length:");
		send_buffer();
		pkt_bytes.delete();
		put_text("Content-Length: 12");
		send_buffer();
		pkt_bytes.delete();
		// every whitespace kind ahead of the digits
		put_text("Content-Length:");
		append_byte(CH_TAB);
		append_byte(CH_LF);
		append_byte(CH_VT);
		append_byte(CH_FF);
		append_byte(CH_CR);
		append_byte(CH_SP);
		send_text("8", 1);
		put_crlf();
		put_crlf();
		send_text("tail", 0);
		wait_results();

		// receiver stalls long while short buffers keep coming
		rx_hold_left = 150;
		repeat (8) begin
			pkt_bytes.delete();
			repeat ($urandom_range(1, 2)) append_byte(8'($urandom_range(255)));
			send_buffer();
		end
		run_random(1, 30);
		wait_results();

		send_idle_pct = 76;
		recv_idle_pct = 20;
		run_random(1, 30);
		wait_results();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_random(1, 30);
		wait_results();

		repeat (10) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("PASS http_header_end_and_length_detector_core");
		else
			$display("FAIL http_header_end_and_length_detector_core");
		$finish;
	end

endmodule

[filelist.f]
+incdir+rtl
rtl/hhed_pkg.sv
rtl/hhed_match.sv
rtl/hhed_number.sv
rtl/http_header_end_and_length_detector_core.sv
tb/http_header_end_and_length_detector_core_tb.sv
